[rtl/rars_pkg.sv]
// shared types and constants for the range add / range sum tree
package rars_pkg;

	localparam int unsigned IDX_W = 10;
	localparam int unsigned AMT_W = 32;
	localparam int unsigned SUM_W = 64;
	localparam int unsigned FUNC_W = 2;

	// operation codes of an input word
	typedef enum logic [FUNC_W-1:0] {
		FUNC_ADD   = 2'd0,
		FUNC_SUM   = 2'd1,
		FUNC_CLEAR = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	// controller states
	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_DISPATCH = 7'b0000010,
		S_READ     = 7'b0000100,
		S_CALC     = 7'b0001000,
		S_WRL      = 7'b0010000,
		S_RESULT   = 7'b0100000,
		S_CLEAR    = 7'b1000000
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic pass_init;
		logic pass_sel;
		logic rd;
		logic calc;
		logic wrl;
		logic step;
		logic clr_wr;
		logic out_load;
	} dp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic is_add;
		logic is_sum;
		logic is_clear;
		logic empty;
		logic has_second;
		logic full;
		logic dir;
		logic sweep_done;
		logic out_free;
	} dp_stat_t;

endpackage

[rtl/rars_ram.sv]
// generic ram, one write port and two registered read ports
module rars_ram #(
	parameter int unsigned WIDTH = 128,
	parameter int unsigned DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read ports, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

[rtl/rars_dp.sv]
// datapath: operands, node walk registers, node memory, accumulator, result register
module rars_dp import rars_pkg::*; #(
	parameter int unsigned ELEMENTS = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [FUNC_W-1:0] func,
	input  logic [IDX_W-1:0]  first_index,
	input  logic [IDX_W-1:0]  last_index,
	input  logic [AMT_W-1:0]  amount,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_wdata,
	input  dp_cmd_t           cmd,
	output dp_stat_t          stat,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [SUM_W-1:0]  range_sum
);

	localparam int unsigned LEVELS  = $clog2(ELEMENTS);
	localparam int unsigned POS_W   = LEVELS;
	localparam int unsigned NODE_W  = LEVELS + 1;
	localparam int unsigned DEPTH   = 2 * (2 ** LEVELS);
	localparam int unsigned RW      = $clog2(LEVELS + 1);
	localparam int unsigned ELEM_M1 = ELEMENTS - 1;
	localparam int unsigned PROD_W  = AMT_W + 1 + POS_W + 2;

	logic [IDX_W-1:0]  top_q;
	logic [FUNC_W-1:0] func_q;
	logic [IDX_W-1:0]  first_q;
	logic [IDX_W-1:0]  last_q;
	logic [AMT_W-1:0]  amount_q;

	logic [POS_W-1:0]        p_q;
	logic signed [AMT_W:0]   v_q;
	logic                    neg_q;
	logic [RW-1:0]           r_q;
	logic [NODE_W-1:0]       node_q;
	logic [SUM_W-1:0]        a_q;
	logic [SUM_W-1:0]        acc_q;
	logic [SUM_W-1:0]        prod_s1;
	logic [NODE_W-1:0]       sweep_q;
	logic                    out_valid_q;
	logic [SUM_W-1:0]        range_sum_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= IDX_W'(1023);
		end else if (cfg_we) begin
			top_q <= cfg_wdata;
		end
	end

	// captured word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q   <= func;
			first_q  <= first_index;
			last_q   <= last_index;
			amount_q <= amount;
		end
	end

	// range clipping and decode
	logic [IDX_W-1:0] limit;
	logic [IDX_W-1:0] b_clip;
	logic [IDX_W-1:0] a_m1;
	logic [31:0]      b32;
	logic [31:0]      a32;
	always_comb begin
		limit  = (32'(top_q) > ELEM_M1) ? IDX_W'(ELEM_M1) : top_q;
		b_clip = (last_q > limit) ? limit : last_q;
		a_m1   = first_q - IDX_W'(1);
		b32    = 32'(b_clip);
		a32    = 32'(a_m1);
	end

	// node walk helpers
	logic [POS_W-1:0]  mask;
	logic [POS_W-1:0]  p_shr;
	logic [RW-1:0]     r_m1;
	logic [POS_W:0]    cnt;
	logic [NODE_W-1:0] left_node;
	logic [NODE_W-1:0] next_node;
	always_comb begin
		mask      = ~({POS_W{1'b1}} << r_q);
		r_m1      = r_q - RW'(1);
		p_shr     = p_q >> r_m1;
		cnt       = {1'b0, p_q & mask} + (POS_W+1)'(1);
		left_node = {node_q[NODE_W-2:0], 1'b0};
		next_node = {node_q[NODE_W-2:0], p_shr[0]};
	end

	// node memory, each entry holds pending add over sum
	logic                    ram_we;
	logic [NODE_W-1:0]       ram_waddr;
	logic [2*SUM_W-1:0]      ram_wdata;
	logic [2*SUM_W-1:0]      rd_n;
	logic [2*SUM_W-1:0]      rd_l;
	logic [SUM_W-1:0]        add_n, sum_n, add_l, sum_l, v64;
	always_comb begin
		add_n = rd_n[2*SUM_W-1:SUM_W];
		sum_n = rd_n[SUM_W-1:0];
		add_l = rd_l[2*SUM_W-1:SUM_W];
		sum_l = rd_l[SUM_W-1:0];
		v64   = SUM_W'(v_q);
	end

	rars_ram #(
		.WIDTH (2 * SUM_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.re      (cmd.rd),
		.raddr_a (node_q),
		.raddr_b (left_node),
		.rdata_a (rd_n),
		.rdata_b (rd_l)
	);

	// memory write select
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = node_q;
		ram_wdata = '0;
		if (cmd.clr_wr) begin
			ram_we    = 1'b1;
			ram_waddr = sweep_q;
		end else if (cmd.calc && stat.is_add) begin
			ram_we    = 1'b1;
			ram_wdata = stat.full ? {add_n + v64, sum_n} : {add_n, sum_n + prod_s1};
		end else if (cmd.wrl) begin
			ram_we    = 1'b1;
			ram_waddr = left_node;
			ram_wdata = {add_l + v64, sum_l};
		end
	end

	// query contributions
	logic [SUM_W-1:0] a_sum;
	logic [SUM_W-1:0] part;
	always_comb begin
		a_sum = a_q + add_n;
		if (stat.full) begin
			part = sum_n + (a_sum << r_q);
		end else if (p_shr[0]) begin
			part = sum_l + ((a_sum + add_l) << r_m1);
		end else begin
			part = '0;
		end
	end

	// walk registers
	logic signed [PROD_W-1:0] prod;
	always_comb begin
		prod = v_q * $signed({2'b00, cnt});
	end

	always_ff @(posedge clk) begin
		if (cmd.pass_init) begin
			p_q    <= cmd.pass_sel ? a32[POS_W-1:0] : b32[POS_W-1:0];
			v_q    <= cmd.pass_sel ? -$signed({amount_q[AMT_W-1], amount_q})
			                       : $signed({amount_q[AMT_W-1], amount_q});
			neg_q  <= cmd.pass_sel;
			r_q    <= RW'(LEVELS);
			node_q <= NODE_W'(1);
			a_q    <= '0;
		end else if (cmd.step) begin
			r_q    <= r_m1;
			node_q <= next_node;
			if (!stat.is_add) begin
				a_q <= a_sum;
			end
		end
		if (cmd.rd) begin
			prod_s1 <= SUM_W'(prod);
		end
	end

	// accumulator for sums
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q <= '0;
		end else if (cmd.calc && stat.is_sum) begin
			acc_q <= neg_q ? acc_q - part : acc_q + part;
		end
	end

	// clearing sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.load) begin
			sweep_q <= '0;
		end else if (cmd.clr_wr) begin
			sweep_q <= sweep_q + NODE_W'(1);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			range_sum_q <= acc_q;
		end
	end

	// status
	always_comb begin
		stat.is_add     = func_q == FUNC_ADD;
		stat.is_sum     = func_q == FUNC_SUM;
		stat.is_clear   = func_q == FUNC_CLEAR;
		stat.empty      = first_q > b_clip;
		stat.has_second = first_q != '0;
		stat.full       = (p_q & mask) == mask;
		stat.dir        = p_shr[0];
		stat.sweep_done = &sweep_q;
		stat.out_free   = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign range_sum = range_sum_q;

endmodule

[rtl/rars_ctrl.sv]
// controller: sequences clearing, the two prefix walks and result hand-off
module rars_ctrl import rars_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd,
	output state_t   state
);

	state_t state_q, state_d;
	logic   pass_q, pass_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			pass_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pass_q  <= pass_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		pass_d   = pass_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				priority if (stat.is_clear) begin
					state_d = S_CLEAR;
				end else if (!(stat.is_add || stat.is_sum)) begin
					state_d = S_IDLE;
				end else if (stat.empty) begin
					state_d = stat.is_sum ? S_RESULT : S_IDLE;
				end else begin
					cmd.pass_init = 1'b1;
					pass_d        = 1'b0;
					state_d       = S_READ;
				end
			end
			S_READ: begin
				cmd.rd  = 1'b1;
				state_d = S_CALC;
			end
			S_CALC: begin
				cmd.calc = 1'b1;
				priority if (stat.full) begin
					if (!pass_q && stat.has_second) begin
						cmd.pass_init = 1'b1;
						cmd.pass_sel  = 1'b1;
						pass_d        = 1'b1;
						state_d       = S_READ;
					end else begin
						state_d = stat.is_sum ? S_RESULT : S_IDLE;
					end
				end else if (stat.is_add && stat.dir) begin
					state_d = S_WRL;
				end else begin
					cmd.step = 1'b1;
					state_d  = S_READ;
				end
			end
			S_WRL: begin
				cmd.wrl  = 1'b1;
				cmd.step = 1'b1;
				state_d  = S_READ;
			end
			S_RESULT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (stat.sweep_done) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign state = state_q;

endmodule

[rtl/range_add_range_sum_tree.sv]
// Range add / range sum store of 64-bit positions 0..min(top_index, ELEMENTS-1), kept as a
// segment tree of 2*2^clog2(ELEMENTS) nodes (pending add and sum per node) in one RAM.
// Every non-empty range operation runs as one or two prefix walks from the root to a leaf, at most
// clog2(ELEMENTS)+1 nodes each: each node is read and then processed, and an add that turns right
// also writes the left child through the RAM write port. A new word is taken only once the
// current one is done, and a sum also waits while the previous result is still held. After
// reset and after each clear the RAM is swept to zero, one node a cycle, while no word is
// accepted. A result waits in an output register while the next word is taken.
module range_add_range_sum_tree import rars_pkg::*; #(
	parameter int unsigned ELEMENTS = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [FUNC_W-1:0] func,
	input  logic [IDX_W-1:0]  first_index,
	input  logic [IDX_W-1:0]  last_index,
	input  logic [AMT_W-1:0]  amount,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [SUM_W-1:0]  range_sum
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	state_t   state;

	// controller
	rars_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd),
		.state    (state)
	);

	// datapath
	rars_dp #(
		.ELEMENTS (ELEMENTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.func        (func),
		.first_index (first_index),
		.last_index  (last_index),
		.amount      (amount),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.cmd         (cmd),
		.stat        (stat),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.range_sum   (range_sum)
	);

	// a word is taken only when idle, and the block is busy right after
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("word accepted while busy");

	// no memory clearing while words are being taken
	a_no_clear_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !cmd.clr_wr)
		else $error("clear sweep while idle");

	// a result is loaded only into a free output register
	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || out_ready))
		else $error("result overwritten");

	// only the result state loads the output register
	a_out_load_state: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> state == S_RESULT)
		else $error("result load outside result state");

endmodule
